@@ src/pgl_pkg.sv @@
// ----------------------------------------------------------------------------
// pgl_pkg: shared types and constants for the polyphase Goertzel lanes
// Lane count, field widths, register indexes, lane operation codes and the
// saturating helpers used by the lanes and the sequencer.
// ----------------------------------------------------------------------------
package pgl_pkg;

  localparam int LANES          = 16;
  localparam int GROUP_SIZE     = 8;
  localparam int LANE_GROUPS    = LANES / GROUP_SIZE;
  localparam int ROWS           = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int ROW_W          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GRP_W          = $clog2(GROUP_SIZE);
  localparam int LAST_ROW_LANES = LANES - GROUP_SIZE * (ROWS - 1);

  localparam int SAMPLE_W   = 16;
  localparam int STATE_W    = 48;
  localparam int ACC_W      = 54;
  localparam int COEF_W     = 19;
  localparam int TRIG_W     = 18;
  localparam int IDX_W      = 6;
  localparam int PAD_W      = 6;
  localparam int VCNT_W     = 4;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_ADDR_W-1:0] REG_COEFF = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COS   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIN   = 2'd2;

  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [GROUP_SIZE-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [GROUP_SIZE-1:0][STATE_W-1:0]  state_vec_t;

  localparam state_t SAT_MAX = state_t'({1'b0, {(STATE_W-1){1'b1}}});
  localparam state_t SAT_MIN = state_t'({1'b1, {(STATE_W-1){1'b0}}});

  typedef enum logic [1:0] {
    OP_STEP,
    OP_IPH,
    OP_QUAD
  } lane_op_t;

  typedef struct packed {
    logic               mul_en;
    logic               clear;
    lane_op_t           op;
    logic [ROW_W-1:0]   row;
    logic signed [COEF_W-1:0] coef;
  } lane_ctrl_t;

  function automatic state_t sat_state(input logic signed [ACC_W-1:0] v);
    state_t r;
    if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
      r = v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

  function automatic logic [PAD_W-1:0] pad_add(input logic [PAD_W-1:0] p,
                                               input logic [VCNT_W-1:0] n);
    logic [PAD_W:0] s;
    s = {1'b0, p} + (PAD_W+1)'(n);
    return s[PAD_W] ? '1 : s[PAD_W-1:0];
  endfunction

endpackage

@@ src/pgl_lane.sv @@
// ----------------------------------------------------------------------------
// pgl_lane: one resonator lane
// Holds s1/s2 for each row it serves, one split 48x19 multiply stage and
// one add/saturate stage; also forms I and Q for the result pass.
// ----------------------------------------------------------------------------
module pgl_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  pgl_pkg::lane_ctrl_t ctrl,
  input  pgl_pkg::sample_t    x,
  output pgl_pkg::state_t     iph,
  output pgl_pkg::state_t     quad
);
  import pgl_pkg::*;

  state_t s1_mem_r [ROWS];
  state_t s2_mem_r [ROWS];

  state_t              s1_rd;
  state_t              s2_rd;
  logic signed [31:0]  hi;
  logic signed [16:0]  lo;
  logic signed [50:0]  p_hi_nxt;
  logic signed [35:0]  p_lo_nxt;

  logic signed [50:0]  p_hi_r;
  logic signed [35:0]  p_lo_r;
  state_t              s1_r;
  state_t              s2_r;
  sample_t             x_r;
  lane_op_t            op_r;
  logic [ROW_W-1:0]    row_r;
  logic                acc_en_r;

  logic signed [36:0]     lo_rnd;
  logic signed [20:0]     lo_sh;
  state_t                 s2_eff;
  sample_t                x_eff;
  logic signed [ACC_W-1:0] acc;
  state_t                 res;
  state_t                 iph_r;
  state_t                 quad_r;

  assign s1_rd = s1_mem_r[ctrl.row];
  assign s2_rd = s2_mem_r[ctrl.row];

  // s1 = hi*2^16 + lo, lo unsigned: round(s1*c/2^16) = c*hi + round(c*lo/2^16)
  assign hi       = signed'(s1_rd[STATE_W-1:16]);
  assign lo       = signed'({1'b0, s1_rd[15:0]});
  assign p_hi_nxt = 51'(ctrl.coef) * 51'(hi);
  assign p_lo_nxt = 36'(ctrl.coef) * 36'(lo);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_hi_r <= p_hi_nxt;
      p_lo_r <= p_lo_nxt;
      s1_r   <= s1_rd;
      s2_r   <= s2_rd;
      x_r    <= x;
      op_r   <= ctrl.op;
      row_r  <= ctrl.row;
    end
  end

  assign lo_rnd = 37'(p_lo_r) + 37'sd32768;
  assign lo_sh  = 21'(lo_rnd >>> 16);
  assign s2_eff = (op_r == OP_QUAD) ? '0 : s2_r;
  assign x_eff  = (op_r == OP_STEP) ? x_r : '0;
  assign acc    = ACC_W'(p_hi_r) + ACC_W'(lo_sh) - ACC_W'(s2_eff) + ACC_W'(x_eff);
  assign res    = sat_state(acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      for (int k = 0; k < ROWS; k++) begin
        s1_mem_r[k] <= '0;
        s2_mem_r[k] <= '0;
      end
    end else begin
      acc_en_r <= ctrl.mul_en;
      if (ctrl.clear) begin
        for (int k = 0; k < ROWS; k++) begin
          s1_mem_r[k] <= '0;
          s2_mem_r[k] <= '0;
        end
      end else if (acc_en_r && op_r == OP_STEP) begin
        s2_mem_r[row_r] <= s1_r;
        s1_mem_r[row_r] <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en_r) begin
      case (op_r)
        OP_IPH:  iph_r  <= res;
        OP_QUAD: quad_r <= res;
        default: ;
      endcase
    end
  end

  assign iph  = iph_r;
  assign quad = quad_r;

endmodule

@@ src/pgl_merge.sv @@
// ----------------------------------------------------------------------------
// pgl_merge: result serializer
// Walks the lanes of one row and hands their I/Q words to the output
// register, one word per cycle whenever the register is free.
// ----------------------------------------------------------------------------
module pgl_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [pgl_pkg::ROW_W-1:0]           row,
  input  logic [pgl_pkg::PAD_W-1:0]           pad,
  input  pgl_pkg::state_vec_t                 iph_vec,
  input  pgl_pkg::state_vec_t                 quad_vec,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [pgl_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  output logic                                busy,
  output logic                                done
);
  import pgl_pkg::*;

  logic              active_r;
  logic [GRP_W-1:0]  cnt_r;
  logic [ROW_W-1:0]  row_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic              out_tlast_r;

  logic              load;
  logic [GRP_W-1:0]  last_cnt;
  logic [IDX_W-1:0]  lane_idx;

  assign load     = active_r && (!out_tvalid_r || out_tready);
  assign last_cnt = (int'(row_r) == ROWS - 1) ? GRP_W'(LAST_ROW_LANES - 1)
                                              : GRP_W'(GROUP_SIZE - 1);
  assign lane_idx = IDX_W'({row_r, cnt_r});
  assign done     = load && (cnt_r == last_cnt);
  assign busy     = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      cnt_r        <= '0;
      row_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
        row_r    <= row;
      end else if (load) begin
        cnt_r <= cnt_r + 1'b1;
        if (done) begin
          active_r <= 1'b0;
        end
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // word: lane_index, in_phase, quadrature, pad_count, zero fill
  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {4'b0, pad, quad_vec[cnt_r], iph_vec[cnt_r], lane_idx};
      out_tlast_r <= (lane_idx == IDX_W'(LANES - 1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ src/polyphase_goertzel_lanes.sv @@
// ----------------------------------------------------------------------------
// polyphase_goertzel_lanes: polyphase Goertzel front end
// Eight resonator lanes step one row of eight samples per input word; on the
// final word of a block every lane reports its I/Q pair, one word per lane.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry eight 16-bit samples plus a valid count; tlast marks
//   the final word of a block. Rows of lanes are filled in turn (lanes
//   8*g..8*g+7 for row g). Samples at and above the valid count are zero.
//   A non-final word goes through accept, multiply and accumulate, as set by
//   the shared two-stage multiply/accumulate path in each lane.
//   A final word additionally steps each unfilled row with zeros, then for
//   every row forms I and then Q and emits up to 8 output words, one per
//   cycle while out_tready is high.
//   Output words leave in lane order; tlast is set on the highest lane.
//   A stalled receiver holds the output register and pauses the row walk;
//   the final word of a block may still wait while the next block starts.
//   Reset clears all lane state, the row pointer, the pad count and the
//   configuration (coeff 0, cosine 1.0, sine 0). Configuration is written
//   via cfg_we/cfg_addr/cfg_wdata; the user, not the block, keeps it to idle.
// ----------------------------------------------------------------------------
module polyphase_goertzel_lanes (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample_0..sample_7 [127:0], valid_count [131:128], zero fill
  input  logic [pgl_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // lane_index [5:0], in_phase [53:6], quadrature [101:54], pad_count [107:102]
  output logic [pgl_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [pgl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pgl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pgl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_EMIT
  } seq_state_t;

  // configuration
  logic signed [COEF_W-1:0] coeff_r;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  // sequencer
  seq_state_t       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] group_r, group_nxt;
  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic             last_r, last_nxt;
  lane_op_t         op_r, op_nxt;
  sample_vec_t      x_r, x_nxt;

  logic [VCNT_W-1:0] vcnt;
  logic [VCNT_W-1:0] vcnt_cl;
  logic [ROW_W-1:0]  row_inc;
  logic              merge_start;
  logic              merge_done;
  logic              merge_busy;
  logic              lane_clear;
  lane_ctrl_t        lane_ctrl;
  state_vec_t        iph_vec;
  state_vec_t        quad_vec;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      cos_r   <= TRIG_W'(65536);
      sin_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEFF: coeff_r <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_COS:   cos_r   <= signed'(cfg_wdata[TRIG_W-1:0]);
        REG_SIN:   sin_r   <= signed'(cfg_wdata[TRIG_W-1:0]);
        default:   ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  assign vcnt    = in_tdata[GROUP_SIZE*SAMPLE_W +: VCNT_W];
  assign vcnt_cl = (vcnt > VCNT_W'(GROUP_SIZE)) ? VCNT_W'(GROUP_SIZE) : vcnt;
  // row pointer wraps after the last whole group of lanes
  assign row_inc = (int'(row_r) + 1 >= LANE_GROUPS) ? '0 : row_r + 1'b1;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    group_nxt   = group_r;
    pad_nxt     = pad_r;
    last_nxt    = last_r;
    op_nxt      = op_r;
    x_nxt       = x_r;
    merge_start = 1'b0;
    lane_clear  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          row_nxt  = group_r;
          op_nxt   = OP_STEP;
          last_nxt = in_tlast;
          for (int j = 0; j < GROUP_SIZE; j++) begin
            x_nxt[j] = (VCNT_W'(j) < vcnt_cl) ? in_tdata[j*SAMPLE_W +: SAMPLE_W] : '0;
          end
          pad_nxt   = pad_add(pad_r, VCNT_W'(GROUP_SIZE) - vcnt_cl);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (op_r)
          OP_STEP: begin
            group_nxt = row_inc;
            if (!last_r) begin
              state_nxt = S_IDLE;
            end else if (row_inc != '0) begin
              // unfilled row of the final pass: step it with zeros
              row_nxt   = row_inc;
              x_nxt     = '0;
              pad_nxt   = pad_add(pad_r, VCNT_W'(GROUP_SIZE));
              state_nxt = S_MUL;
            end else begin
              row_nxt   = '0;
              op_nxt    = OP_IPH;
              state_nxt = S_MUL;
            end
          end
          OP_IPH: begin
            op_nxt    = OP_QUAD;
            state_nxt = S_MUL;
          end
          default: begin
            merge_start = 1'b1;
            state_nxt   = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        if (merge_done) begin
          if (int'(row_r) == ROWS - 1) begin
            lane_clear = 1'b1;
            group_nxt  = '0;
            pad_nxt    = '0;
            state_nxt  = S_IDLE;
          end else begin
            row_nxt   = row_r + 1'b1;
            op_nxt    = OP_IPH;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      group_r <= '0;
      pad_r   <= '0;
      last_r  <= 1'b0;
      op_r    <= OP_STEP;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      group_r <= group_nxt;
      pad_r   <= pad_nxt;
      last_r  <= last_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // ---------------- lanes ----------------
  always_comb begin
    lane_ctrl.mul_en = (state_r == S_MUL);
    lane_ctrl.clear  = lane_clear;
    lane_ctrl.op     = op_r;
    lane_ctrl.row    = row_r;
    case (op_r)
      OP_IPH:  lane_ctrl.coef = COEF_W'(cos_r);
      OP_QUAD: lane_ctrl.coef = COEF_W'(sin_r);
      default: lane_ctrl.coef = coeff_r;
    endcase
  end

  for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_lane
    pgl_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .x     (x_r[j]),
      .iph   (iph_vec[j]),
      .quad  (quad_vec[j])
    );
  end

  // ---------------- result serializer ----------------
  pgl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (merge_start),
    .row        (row_r),
    .pad        (pad_r),
    .iph_vec    (iph_vec),
    .quad_vec   (quad_vec),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .busy       (merge_busy),
    .done       (merge_done)
  );

  // ---------------- assertions ----------------
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !merge_busy)
    else $error("input word accepted while results are being walked");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctrl.mul_en |=> !lane_ctrl.mul_en)
    else $error("lane multiply issued back to back");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctrl.clear |=> (group_r == '0 && pad_r == '0 && state_r == S_IDLE))
    else $error("block end did not return the sequencer to its start");

  a_done_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> (state_r == S_EMIT))
    else $error("serializer finished outside the result pass");

endmodule
